@@ design/pcm_pkg.sv @@
// Shared types and constants for the PCM channel mixer.
package pcm_pkg;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_GAINS  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam int unsigned SEP_MAX      = 254;
  localparam int unsigned DEFAULT_RATE = 11025;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_START,
    CMD_GAINS,
    CMD_STOP,
    CMD_TICK,
    CMD_NONE,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  voice;
    logic        voice_ok;
    logic [19:0] address;
    logic [7:0]  sample_byte;
    logic [15:0] sample_count;
    logic [15:0] source_rate;
    logic [6:0]  volume;
    logic [7:0]  separation;
  } cmd_t;

  // Both gains from volume and separation; divide by 127 via reciprocal.
  function automatic logic [8:0] div127(input logic [14:0] x);
    logic [31:0] p;
    logic [15:0] q;
    logic [15:0] r;
    begin
      p = 32'(x) * 32'd33026;
      q = p[31:22];
      r = 16'(x) - 16'(q * 16'd127);
      if (r >= 16'd127) q = q + 16'd1;
      div127 = q[8:0];
    end
  endfunction

endpackage

@@ design/pcm_front.sv @@
// Front end: classifies commands and pushes them into the queue.
module pcm_front import pcm_pkg::*; #(
  parameter int VOICES = 8,
  parameter int AW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  operation,
  input  logic [2:0]  voice,
  input  logic [15:0] address,
  input  logic [7:0]  sample_byte,
  input  logic [15:0] sample_count,
  input  logic [15:0] source_rate,
  input  logic [6:0]  volume,
  input  logic [7:0]  separation,
  input  logic        accept,
  output logic        push,
  output cmd_t        cmd
);

  cmd_kind_t kind;

  always_comb begin
    case (operation)
      OP_WRITE: kind = CMD_WRITE;
      OP_START: kind = (sample_count == 16'd0) ? CMD_REJECT : CMD_START;
      OP_GAINS: kind = CMD_GAINS;
      OP_STOP:  kind = CMD_STOP;
      OP_TICK:  kind = CMD_TICK;
      default:  kind = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= accept;
    end
    if (accept) begin
      cmd.kind         <= kind;
      cmd.voice        <= 4'(voice);
      cmd.voice_ok     <= 32'(voice) < VOICES;
      cmd.address      <= 20'(address[AW > 16 ? 15 : AW-1:0]);
      cmd.sample_byte  <= sample_byte;
      cmd.sample_count <= sample_count;
      cmd.source_rate  <= (source_rate == 16'd0) ? 16'(DEFAULT_RATE) : source_rate;
      cmd.volume       <= volume;
      cmd.separation   <= (separation > 8'(SEP_MAX)) ? 8'(SEP_MAX) : separation;
    end
  end

endmodule

@@ design/pcm_back.sv @@
// Back end: voice state, sample memory and the per-voice tick walk.
module pcm_back import pcm_pkg::*; #(
  parameter int VOICES = 8,
  parameter int DEPTH = 65536,
  parameter int OUTPUT_RATE = 11025
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  cmd_t               cmd,
  output logic               pop,
  output logic               done,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic [7:0]         active_voices,
  output logic               status
);

  localparam int AW = $clog2(DEPTH);
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [39:0] RECIP = 40'((64'd1 << 48) / OUTPUT_RATE + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP1, S_STEP2, S_GAIN1, S_GAIN2,
    S_TADDR, S_TREAD, S_TMUL, S_TACC, S_FINISH
  } state_t;

  state_t state;
  logic [7:0] mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [7:0] rd_data;

  logic [VOICES-1:0] act;
  logic [15:0] vbase [VOICES];
  logic [15:0] vlen [VOICES];
  logic [31:0] vpos [VOICES];
  logic [18:0] vstep [VOICES];
  logic [8:0] lgain [VOICES];
  logic [8:0] rgain [VOICES];

  logic [VW-1:0] cur;
  logic [VW:0] cnt;
  logic [55:0] prod;
  logic [14:0] lnum, rnum;
  logic signed [17:0] lmul, rmul;
  logic signed [23:0] lsum, rsum;
  logic [3:0] vi;
  logic [VW-1:0] vsel;

  assign vi = cmd.voice;
  assign vsel = VW'(vi);

  function automatic logic signed [15:0] sat(input logic signed [23:0] x);
    if (x > 24'sd32767) sat = 16'sh7fff;
    else if (x < -24'sd32768) sat = 16'sh8000;
    else sat = x[15:0];
  endfunction

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (pop && cmd.kind == CMD_WRITE) mem[AW'(cmd.address)] <= cmd.sample_byte;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) active_voices[i] = (i < VOICES) ? act[i] : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act <= '0;
      done <= 1'b0;
      pop <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        vbase[i] <= '0; vlen[i] <= '0; vpos[i] <= '0; vstep[i] <= '0;
        lgain[i] <= '0; rgain[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      pop <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop_valid && !pop) begin
            left_sample <= '0;
            right_sample <= '0;
            status <= 1'b0;
            case (cmd.kind)
              CMD_WRITE, CMD_NONE: begin
                pop <= 1'b1; done <= 1'b1;
              end
              CMD_REJECT: begin
                status <= 1'b1; pop <= 1'b1; done <= 1'b1;
              end
              CMD_STOP: begin
                if (cmd.voice_ok) act[vsel] <= 1'b0;
                pop <= 1'b1; done <= 1'b1;
              end
              CMD_START: begin
                if (cmd.voice_ok) state <= S_STEP1;
                else begin pop <= 1'b1; done <= 1'b1; end
              end
              CMD_GAINS: begin
                if (cmd.voice_ok) state <= S_GAIN1;
                else begin pop <= 1'b1; done <= 1'b1; end
              end
              CMD_TICK: begin
                lsum <= '0; rsum <= '0; cur <= '0; cnt <= '0;
                state <= S_TADDR;
              end
              default: begin pop <= 1'b1; done <= 1'b1; end
            endcase
          end
        end
        S_STEP1: begin
          prod <= 56'(cmd.source_rate) * 56'(RECIP);
          state <= S_STEP2;
        end
        S_STEP2: begin
          vstep[vsel] <= prod[50:32];
          act[vsel] <= 1'b1;
          vbase[vsel] <= cmd.address[15:0];
          vlen[vsel] <= cmd.sample_count;
          vpos[vsel] <= '0;
          state <= S_GAIN1;
        end
        S_GAIN1: begin
          lnum <= 15'(8'(SEP_MAX) - cmd.separation) * 15'(cmd.volume);
          rnum <= 15'(cmd.separation) * 15'(cmd.volume);
          state <= S_GAIN2;
        end
        S_GAIN2: begin
          lgain[vsel] <= div127(lnum);
          rgain[vsel] <= div127(rnum);
          pop <= 1'b1; done <= 1'b1;
          state <= S_IDLE;
        end
        S_TADDR: begin
          rd_addr <= AW'(vbase[cur] + vpos[cur][31:16]);
          state <= S_TREAD;
        end
        S_TREAD: state <= S_TMUL;
        S_TMUL: begin
          lmul <= $signed({1'b0, rd_data}) - 18'sd128;
          rmul <= $signed({1'b0, rd_data}) - 18'sd128;
          state <= S_TACC;
        end
        S_TACC: begin
          if (act[cur]) begin
            if (vpos[cur][31:16] >= vlen[cur]) act[cur] <= 1'b0;
            else begin
              lsum <= lsum + 24'(lmul * $signed({1'b0, lgain[cur]}));
              rsum <= rsum + 24'(rmul * $signed({1'b0, rgain[cur]}));
              vpos[cur] <= vpos[cur] + 32'(vstep[cur]);
            end
          end
          if (32'(cnt) == VOICES - 1) state <= S_FINISH;
          else begin
            cur <= cur + 1'b1; cnt <= cnt + 1'b1; state <= S_TADDR;
          end
        end
        S_FINISH: begin
          left_sample <= sat(lsum);
          right_sample <= sat(rsum);
          pop <= 1'b1; done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/pcm_queue.sv @@
// Two-entry command queue between front and back.
module pcm_queue import pcm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output logic valid,
  output logic full,
  output cmd_t dout
);

  cmd_t q [2];
  logic rp, wp;
  logic [1:0] cnt;

  assign valid = cnt != 2'd0;
  assign full = cnt == 2'd2;
  assign dout = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= din;
    if (rst) begin
      rp <= 1'b0; wp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ design/pcm_channel_mixer.sv @@
// Top level of the eight-voice PCM channel mixer.
//  channel | handshake          | payload
//  command | start / busy       | operation voice address sample_byte ...
//  result  | strobe (no stall)  | left_sample right_sample active_voices status
// Write, stop, reject and unknown codes finish from idle; set gains steps
// through S_GAIN1 and S_GAIN2, start through S_STEP1 and S_STEP2 first; a tick
// walks the voices one at a time through the sample memory read port.
// The next item can be accepted in the cycle after the strobe.
// Reset is synchronous and clears voice state; the sample memory is not cleared.
// busy is high while an item is queued or being carried out.
module pcm_channel_mixer import pcm_pkg::*; #(
  parameter int VOICES = 8,
  parameter int SAMPLE_MEMORY_DEPTH = 65536,
  parameter int OUTPUT_RATE = 11025
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic [2:0]         voice,
  input  logic [15:0]        address,
  input  logic [7:0]         sample_byte,
  input  logic [15:0]        sample_count,
  input  logic [15:0]        source_rate,
  input  logic [6:0]         volume,
  input  logic [7:0]         separation,
  output logic               strobe,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic [7:0]         active_voices,
  output logic               status
);

  logic accept, push, qvalid, qfull, pop, inflight;
  cmd_t fcmd, qcmd;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) inflight <= 1'b0;
    else if (accept) inflight <= 1'b1;
    else if (strobe) inflight <= 1'b0;
  end

  assign busy = inflight;

  pcm_front #(.VOICES(VOICES), .AW(16)) u_front (
    .clk, .rst, .operation, .voice, .address, .sample_byte,
    .sample_count, .source_rate, .volume, .separation,
    .accept, .push, .cmd(fcmd)
  );

  pcm_queue u_queue (
    .clk, .rst, .push, .din(fcmd), .pop, .valid(qvalid), .full(qfull), .dout(qcmd)
  );

  pcm_back #(.VOICES(VOICES), .DEPTH(SAMPLE_MEMORY_DEPTH),
    .OUTPUT_RATE(OUTPUT_RATE)) u_back (
    .clk, .rst, .pop_valid(qvalid), .cmd(qcmd), .pop, .done(strobe),
    .left_sample, .right_sample, .active_voices, .status
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && qfull))
    else $error("queue overflow");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result without item");
  a_idle_mask: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> (left_sample == 16'sd0 && right_sample == 16'sd0))
    else $error("reject carried samples");
`endif

endmodule

@@ sim/pcm_channel_mixer_tb.sv @@
// Self-checking testbench for the eight-voice PCM channel mixer.
`timescale 1ns / 1ps

module pcm_channel_mixer_tb;
  import pcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] operation = OP_TICK;
  logic [2:0] voice = '0;
  logic [15:0] address = '0;
  logic [7:0] sample_byte = '0;
  logic [15:0] sample_count = '0;
  logic [15:0] source_rate = '0;
  logic [6:0] volume = '0;
  logic [7:0] separation = '0;
  logic strobe;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [7:0] active_voices;
  logic status;

  pcm_channel_mixer DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [7:0] mask;
    logic rejected;
  } mix_t;

  // mixer state mirror
  logic [7:0] mem_bytes [int];
  logic [7:0] playing;
  logic [15:0] base_addr [8];
  logic [15:0] length [8];
  logic [31:0] position [8];
  logic [31:0] step [8];
  int unsigned gain_l [8];
  int unsigned gain_r [8];

  mix_t mix_queue [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  bit timed_out = 0;

  task automatic apply_gains(input int v, input logic [6:0] vol, input logic [7:0] sep);
    int unsigned s;
    s = (sep > SEP_MAX) ? SEP_MAX : sep;
    gain_l[v] = ((SEP_MAX - s) * vol) / 127;
    gain_r[v] = (s * vol) / 127;
  endtask

  function automatic int clamp16(input int x);
    return (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
  endfunction

  task automatic predict_mix(input logic [2:0] op, input logic [2:0] v,
                             input logic [15:0] a, input logic [7:0] b,
                             input logic [15:0] cnt, input logic [15:0] rate,
                             input logic [6:0] vol, input logic [7:0] sep);
    mix_t r;
    int lsum, rsum, c, centred;
    int unsigned idx, rt;
    lsum = 0;
    rsum = 0;
    r = '0;
    case (op)
      OP_WRITE: mem_bytes[a] = b;
      OP_START: begin
        if (cnt == 0) r.rejected = 1'b1;
        else begin
          rt = (rate == 0) ? DEFAULT_RATE : rate;
          playing[v] = 1'b1;
          base_addr[v] = a;
          length[v] = cnt;
          position[v] = 0;
          step[v] = 32'((longint'(rt) << 16) / 11025);
          apply_gains(v, vol, sep);
        end
      end
      OP_GAINS: apply_gains(v, vol, sep);
      OP_STOP: playing[v] = 1'b0;
      OP_TICK: begin
        for (c = 0; c < 8; c++) begin
          if (!playing[c]) continue;
          idx = position[c] >> 16;
          if (idx >= length[c]) begin
            playing[c] = 1'b0;
            continue;
          end
          centred = int'(mem_bytes[16'(base_addr[c] + idx)]) - 128;
          lsum += centred * int'(gain_l[c]);
          rsum += centred * int'(gain_r[c]);
          position[c] += step[c];
        end
        r.left = 16'(clamp16(lsum));
        r.right = 16'(clamp16(rsum));
      end
      default: ;
    endcase
    r.mask = playing;
    mix_queue.push_back(r);
  endtask

  task automatic send_item(input logic [2:0] op, input logic [2:0] v,
                           input logic [15:0] a, input logic [7:0] b,
                           input logic [15:0] cnt, input logic [15:0] rate,
                           input logic [6:0] vol, input logic [7:0] sep);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    operation <= op;
    voice <= v;
    address <= a;
    sample_byte <= b;
    sample_count <= cnt;
    source_rate <= rate;
    volume <= vol;
    separation <= sep;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_mix(op, v, a, b, cnt, rate, vol, sep);
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    mix_t got, want;
    if (!rst && strobe) begin
      got = '{left_sample, right_sample, active_voices, status};
      if (mix_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = mix_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected L=%0d R=%0d mask=%h st=%b, got L=%0d R=%0d mask=%h st=%b",
                     want.left, want.right, want.mask, want.rejected,
                     got.left, got.right, got.mask, got.rejected);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  // written sample region used by voices
  logic [15:0] written [$];

  task automatic fill_bytes(input logic [15:0] a, input int n, input bit edge_values);
    int i;
    for (i = 0; i < n; i++) begin
      send_item(OP_WRITE, 0, 16'(a + i),
                edge_values ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom),
                0, 0, 0, 0);
      written.push_back(16'(a + i));
    end
  endtask

  task automatic test_directed();
    int v;
    fill_bytes(16'hFFFC, 8, 1);
    send_item(OP_START, 3'd0, 16'hFFFC, 0, 16'd0, 0, 7'd127, 8'd0);
    send_item(OP_START, 3'd0, 16'hFFFC, 0, 16'd8, 16'd0, 7'd127, 8'd0);
    send_item(OP_START, 3'd1, 16'hFFFC, 0, 16'd8, 16'd11025, 7'd127, 8'd255);
    send_item(OP_START, 3'd2, 16'hFFFC, 0, 16'd8, 16'd22050, 7'd127, 8'd127);
    for (v = 3; v < 8; v++)
      send_item(OP_START, 3'(v), 16'hFFFC, 0, 16'd8, 16'd65535, 7'd127, 8'd254);
    send_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_GAINS, 3'd7, 0, 0, 0, 0, 7'd0, 8'd0);
    send_item(OP_STOP, 3'd6, 0, 0, 0, 0, 0, 0);
    send_item(OP_STOP, 3'd6, 0, 0, 0, 0, 0, 0);
    send_item(3'd5, 3'd7, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 7'h7F, 8'hFF);
    send_item(3'd7, 0, 0, 0, 0, 0, 0, 0);
    repeat (10) send_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int n);
    int i, k;
    logic [15:0] b;
    logic [15:0] cnt;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 10) fill_bytes(16'($urandom), 1, 0);
      else if (k < 25) begin
        // base within written memory, length kept inside it
        k = $urandom_range(written.size() - 1);
        b = written[k];
        cnt = 1;
        while (k + cnt < written.size() && written[k + cnt] == 16'(b + cnt)
               && $urandom_range(3) != 0) cnt++;
        if ($urandom_range(19) == 0) cnt = 0;
        send_item(OP_START, 3'($urandom), b, 8'($urandom), cnt,
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(22050)),
                  7'($urandom), 8'($urandom));
      end else if (k < 30)
        send_item(OP_GAINS, 3'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom), 7'($urandom), 8'($urandom));
      else if (k < 34)
        send_item(OP_STOP, 3'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom), 7'($urandom), 8'($urandom));
      else if (k < 36)
        send_item(3'($urandom_range(7, 5)), 3'($urandom), 16'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom), 7'($urandom), 8'($urandom));
      else send_item(OP_TICK, 3'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                     16'($urandom), 7'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int n;
    playing = '0;
    for (n = 0; n < 8; n++) begin
      base_addr[n] = 0; length[n] = 0; position[n] = 0; step[n] = 0;
      gain_l[n] = 0; gain_r[n] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // contiguous run of random bytes for voices to play
    fill_bytes(16'h1000, 64, 0);
    send_idle_pct = 27;
    test_directed();
    test_random(150);
    send_idle_pct = 51;
    test_random(150);
    send_idle_pct = 0;
    test_random(150);
    n = 0;
    while (mix_queue.size() != 0 && n < WATCHDOG_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && mix_queue.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
